/* hw/rtl/fsad_pkg.sv */
package fsad_pkg;

  localparam int unsigned ExpBias   = 127;
  localparam int unsigned SigW      = 24;
  localparam int unsigned ExpW      = 11;
  localparam logic [30:0] MaxFinite = 31'h7F7FFFFF;
  localparam logic [30:0] MinNormal = 31'h00800000;

  typedef struct packed {
    logic [31:0] guess_bits;
    logic [31:0] target_bits;
  } in_beat_t;

  typedef struct packed {
    logic [30:0] difference_bits;
    logic        range_error;
  } out_beat_t;

  // Signed exponent wide enough for every intermediate value.
  typedef logic signed [ExpW-1:0] exp_t;

  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd24;
    found = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 5'(23 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

/* hw/rtl/fsad_if.sv */
interface fsad_in_if;
  import fsad_pkg::*;
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fsad_out_if;
  import fsad_pkg::*;
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/fsad_square.sv */
module fsad_square (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  fsad_pkg::in_beat_t    beat_i,
  output logic                  valid_o,
  output logic [47:0]           prod_o,
  output fsad_pkg::exp_t        sq_exp_o,
  output logic [7:0]            t_exp_o,
  output logic [23:0]           t_sig_o
);
  import fsad_pkg::*;

  logic [23:0] g_sig;
  logic        valid_q;
  logic [47:0] prod_q;
  exp_t        sq_exp_q;
  logic [7:0]  t_exp_q;
  logic [23:0] t_sig_q;

  assign g_sig = {1'b1, beat_i.guess_bits[22:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= g_sig * g_sig;
      sq_exp_q <= exp_t'({3'b0, beat_i.guess_bits[30:23]}) * exp_t'(2) - exp_t'(ExpBias);
      t_exp_q  <= beat_i.target_bits[30:23];
      t_sig_q  <= {1'b1, beat_i.target_bits[22:0]};
    end
  end

  assign valid_o  = valid_q;
  assign prod_o   = prod_q;
  assign sq_exp_o = sq_exp_q;
  assign t_exp_o  = t_exp_q;
  assign t_sig_o  = t_sig_q;
endmodule

/* hw/rtl/fsad_align.sv */
module fsad_align (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [47:0]    prod_i,
  input  fsad_pkg::exp_t sq_exp_i,
  input  logic [7:0]     t_exp_i,
  input  logic [23:0]    t_sig_i,
  output logic           valid_o,
  output logic [24:0]    diff_o,
  output fsad_pkg::exp_t exp_o
);
  import fsad_pkg::*;

  logic [24:0] sq;
  logic [24:0] sq_al;
  logic [24:0] t_al;
  exp_t        e;
  exp_t        te;
  exp_t        sh;
  logic        valid_q;
  logic [24:0] diff_q;
  exp_t        exp_q;

  always_comb begin
    sq = prod_i[47:23];
    e  = sq_exp_i;
    if (sq[24]) begin
      sq = sq >> 1;
      e  = e + exp_t'(1);
    end
    te    = exp_t'({3'b0, t_exp_i});
    sq_al = sq;
    t_al  = {1'b0, t_sig_i};
    if (e > te) begin
      sh   = e - te;
      t_al = (sh >= exp_t'(SigW)) ? '0 : t_al >> sh[4:0];
    end else if (te > e) begin
      sh    = te - e;
      sq_al = (sh >= exp_t'(SigW)) ? '0 : sq_al >> sh[4:0];
      e     = te;
    end else begin
      sh = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      diff_q <= (sq_al > t_al) ? sq_al - t_al : t_al - sq_al;
      exp_q  <= e;
    end
  end

  assign valid_o = valid_q;
  assign diff_o  = diff_q;
  assign exp_o   = exp_q;
endmodule

/* hw/rtl/fsad_norm.sv */
module fsad_norm (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [24:0]          diff_i,
  input  fsad_pkg::exp_t       exp_i,
  output logic                 valid_o,
  output fsad_pkg::out_beat_t  beat_o
);
  import fsad_pkg::*;

  logic [4:0]  lz;
  logic [23:0] d;
  exp_t        e;
  out_beat_t   res;
  logic        valid_q;
  out_beat_t   beat_q;

  always_comb begin
    lz  = lzc24(diff_i[23:0]);
    d   = diff_i[23:0] << lz;
    e   = exp_i - exp_t'({6'b0, lz});
    res = '0;
    if (diff_i != '0) begin
      if (e > exp_t'(254)) begin
        res.difference_bits = MaxFinite;
        res.range_error     = 1'b1;
      end else if (e < exp_t'(1)) begin
        res.difference_bits = MinNormal;
        res.range_error     = 1'b1;
      end else begin
        res.difference_bits = {e[7:0], d[22:0]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      beat_q <= res;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;
endmodule

/* hw/rtl/float_square_abs_difference_core.sv */
// Computes |g*g - n| for two single-precision operands, truncating throughout.
// The in channel carries guess_bits and target_bits; the out channel carries
// difference_bits, the result without its sign bit, and range_error, which is
// set when the result exponent fell outside the normal range and the result
// was saturated. A zero difference gives +0.
// Every operand is handled as a positive normal number.
// The pipeline has three stages: significand square, alignment with
// subtraction, and normalisation, each ending in a register. One beat per
// cycle is accepted while the output register is empty or the receiver
// takes its beat.
// When the receiver holds ready low while the output register holds an untaken
// beat, the whole pipeline freezes and the input ready falls; only then does it
// fall, so no beat is lost or repeated.
// Reset clears all valid bits, so the input ready is high when reset is released.
module float_square_abs_difference_core (
  input  logic clk_i,
  input  logic rst_ni,
  fsad_in_if.sink    in_i,
  fsad_out_if.source out_o
);
  import fsad_pkg::*;

  logic        en;
  logic        v1, v2, v3;
  logic [47:0] prod;
  exp_t        sq_exp, exp2;
  logic [7:0]  t_exp;
  logic [23:0] t_sig;
  logic [24:0] diff;
  out_beat_t   res;

  assign en         = !v3 || out_o.ready;
  assign in_i.ready = en;

  fsad_square u_square (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_i.valid), .beat_i(in_i.data),
    .valid_o(v1), .prod_o(prod), .sq_exp_o(sq_exp), .t_exp_o(t_exp), .t_sig_o(t_sig)
  );

  fsad_align u_align (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1), .prod_i(prod), .sq_exp_i(sq_exp),
    .t_exp_i(t_exp), .t_sig_i(t_sig), .valid_o(v2), .diff_o(diff), .exp_o(exp2)
  );

  fsad_norm u_norm (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2), .diff_i(diff), .exp_i(exp2),
    .valid_o(v3), .beat_o(res)
  );

  assign out_o.valid = v3;
  assign out_o.data  = res;
endmodule

/* bench/float_square_abs_difference_core_test.sv */
module float_square_abs_difference_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fsad_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  typedef struct {
    logic [31:0] guess;
    logic [31:0] target;
    logic        known;
    logic [30:0] diff;
    logic        rerr;
  } row_t;

  logic clk_i;
  logic rst_ni;

  fsad_in_if  in_ch ();
  fsad_out_if out_ch ();

  float_square_abs_difference_core u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  out_beat_t   diff_queue[$];
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  function automatic out_beat_t square_abs_diff(logic [31:0] g, logic [31:0] t);
    out_beat_t   r;
    int          e;
    int          te;
    logic [63:0] prod;
    logic [31:0] sq;
    logic [31:0] ts;
    logic [31:0] d;
    int          sh;
    e    = 2 * int'(g[30:23]) - int'(ExpBias);
    te   = int'(t[30:23]);
    prod = {40'd0, 1'b1, g[22:0]} * {40'd0, 1'b1, g[22:0]};
    sq   = prod[54:23];
    ts   = {8'd0, 1'b1, t[22:0]};
    if (sq > 32'h00FFFFFF) begin
      sq = sq >> 1;
      e  = e + 1;
    end
    if (e > te) begin
      sh = e - te;
      ts = (sh >= 24) ? 32'd0 : ts >> sh;
    end else if (te > e) begin
      sh = te - e;
      sq = (sh >= 24) ? 32'd0 : sq >> sh;
      e  = te;
    end
    d = (sq > ts) ? sq - ts : ts - sq;
    r.range_error = 1'b0;
    if (d == 0) begin
      r.difference_bits = '0;
    end else begin
      while (d < 32'h00800000) begin
        d = d << 1;
        e = e - 1;
      end
      if (e > 254) begin
        r.difference_bits = MaxFinite;
        r.range_error     = 1'b1;
      end else if (e < 1) begin
        r.difference_bits = MinNormal;
        r.range_error     = 1'b1;
      end else begin
        r.difference_bits = {8'(e), d[22:0]};
      end
    end
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Receiver: ready changes at the falling edge, beats are checked at the rising edge.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    out_beat_t want;
    cycle_count <= cycle_count + 1;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (diff_queue.size() == 0) begin
        fail_count = fail_count + 1;
        if (fail_count <= 10) $display("unexpected beat %h", out_ch.data);
      end else begin
        want = diff_queue.pop_front();
        if (out_ch.data.difference_bits !== want.difference_bits ||
            out_ch.data.range_error !== want.range_error) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10)
            $display("expected %h/%b, got %h/%b", want.difference_bits, want.range_error,
                     out_ch.data.difference_bits, out_ch.data.range_error);
        end
      end
    end
    if (cycle_count >= CycleLimit) begin
      $display("float_square_abs_difference_core: mismatch");
      $finish;
    end
  end

  task automatic send_pair(row_t row);
    out_beat_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= {row.guess, row.target};
    do @(posedge clk_i); while (!in_ch.ready);
    want = square_abs_diff(row.guess, row.target);
    if (row.known) begin
      want.difference_bits = row.diff;
      want.range_error     = row.rerr;
    end
    diff_queue.push_back(want);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_float(int unsigned lo, int unsigned hi);
    return {1'($urandom), 8'($urandom_range(hi, lo)), 23'($urandom)};
  endfunction

  row_t directed[] = '{
    '{32'h3F800000, 32'h3F800000, 1, 31'h0,        0},
    '{32'h40000000, 32'h40800000, 1, 31'h0,        0},
    '{32'h40000000, 32'h3F800000, 1, 31'h40400000, 0},
    '{32'h7F800000, 32'h3F800000, 1, 31'h7F7FFFFF, 1},
    '{32'h7FFFFFFF, 32'h00000000, 1, 31'h7F7FFFFF, 1},
    '{32'h00000000, 32'h00000000, 1, 31'h00800000, 1},
    '{32'h80000000, 32'h80000000, 1, 31'h00800000, 1},
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 0, 31'h0,        0},
    '{32'h3FFFFFFF, 32'h3F800000, 0, 31'h0,        0},
    '{32'h3F800000, 32'h7F7FFFFF, 0, 31'h0,        0},
    '{32'h3F800000, 32'h4C000000, 0, 31'h0,        0},
    '{32'h3F800000, 32'h4B800000, 0, 31'h0,        0},
    '{32'h46000000, 32'h3F800000, 0, 31'h0,        0},
    '{32'h3F800001, 32'h3F800002, 0, 31'h0,        0},
    '{32'h3FB504F3, 32'h40000000, 0, 31'h0,        0},
    '{32'h20000000, 32'h00800000, 0, 31'h0,        0},
    '{32'h5F800000, 32'h7F7FFFFF, 0, 31'h0,        0},
    '{32'h55555555, 32'hAAAAAAAA, 0, 31'h0,        0},
    '{32'hAAAAAAAA, 32'h55555555, 0, 31'h0,        0}
  };

  initial begin
    row_t        row;
    int unsigned phase_idle[4];
    int unsigned phase_stall[4];
    phase_idle     = '{0, 70, 0, 6};
    phase_stall    = '{0, 0, 70, 6};
    fail_count     = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    in_ch.valid    = 1'b0;
    in_ch.data     = '0;
    @(posedge rst_ni);
    @(negedge clk_i);
    foreach (directed[i]) send_pair(directed[i]);
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      for (int i = 0; i < 400; i++) begin
        row.known = 0;
        case ($urandom_range(3))
          0: begin
            row.guess  = $urandom;
            row.target = $urandom;
          end
          1: begin
            row.guess  = rand_float(100, 150);
            row.target = rand_float(80, 180);
          end
          2: begin
            row.guess  = rand_float(120, 134);
            row.target = {1'($urandom), 8'(2 * int'(row.guess[30:23]) - 127 +
                          $urandom_range(2)), 23'($urandom)};
          end
          default: begin
            row.guess  = $urandom;
            row.target = row.guess;
          end
        endcase
        send_pair(row);
        if (p == 1 && i == 200) begin
          in_ch.valid <= 1'b0;
          wait (diff_queue.size() == 0);
          @(negedge clk_i);
        end
      end
    end
    in_ch.valid <= 1'b0;
    wait (diff_queue.size() == 0);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("float_square_abs_difference_core: match");
    end else begin
      $display("float_square_abs_difference_core: mismatch");
    end
    $finish;
  end
endmodule
